@@ design/rmssd_pkg.sv @@
// Shared types and constants for the RMSSD stress index block.
package rmssd_pkg;

  localparam int IBI_W = 12;
  localparam int BPM_W = 8;
  localparam int RMSSD_W = 16;
  localparam int STRESS_W = 7;
  localparam int MIN_BEATS_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Operation codes of an input item.
  localparam logic OP_BEAT = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register word index (paddr[2]).
  localparam logic CFG_IDX_MIN_BEATS = 1'b0;
  localparam logic [MIN_BEATS_W-1:0] MIN_BEATS_RESET = 4'd6;

  // Stress mapping, in 1/80 units of the index.
  localparam logic [RMSSD_W-1:0] Q_LOW = 16'd160;
  localparam logic [RMSSD_W-1:0] Q_HIGH = 16'd960;
  localparam logic [13:0] S80_BASE = 14'd7200;
  localparam logic [13:0] S80_SLOPE = 14'd7;
  localparam logic [13:0] S80_ROUND = 14'd40;
  localparam logic [13:0] S80_BONUS_HIGH = 14'd640;
  localparam logic [13:0] S80_BONUS_MID = 14'd320;
  localparam logic [13:0] S80_BONUS_LOW = 14'd160;
  localparam logic [BPM_W-1:0] BPM_HIGH = 8'd100;
  localparam logic [BPM_W-1:0] BPM_MID = 8'd90;
  localparam logic [BPM_W-1:0] BPM_LOW = 8'd55;
  // floor(y / 5) == (y * 205) >> 10 for y below 1024
  localparam logic [7:0] DIV5_RECIP = 8'd205;

  typedef struct packed {
    logic                operation;
    logic [IBI_W-1:0]    interval_ms;
    logic [BPM_W-1:0]    heart_rate_bpm;
  } in_item_t;

  typedef struct packed {
    logic                result_valid;
    logic [RMSSD_W-1:0]  rmssd_q4;
    logic [STRESS_W-1:0] stress_index;
  } out_item_t;

  typedef enum logic {
    ITER_DIV,
    ITER_SQRT
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctrl_t;

endpackage

@@ design/rmssd_ring.sv @@
// Interval history memory: one write port, one registered read port.
module rmssd_ring #(
  parameter int DEPTH = 12,
  parameter int AW = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rmssd_pkg::IBI_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [rmssd_pkg::IBI_W-1:0] rdata
);
  import rmssd_pkg::*;

  logic [IBI_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rmssd_iter.sv @@
// Shared compare-subtract unit: restoring division and digit-by-digit square root.
module rmssd_iter #(
  parameter int NUM_W = 36,
  parameter int ROOT_W = 18,
  parameter int DIV_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmssd_pkg::iter_ctrl_t ctrl,
  input  logic [NUM_W-1:0]      operand,
  input  logic [DIV_W-1:0]      divisor,
  output logic [NUM_W-1:0]      result,
  output logic                  done
);
  import rmssd_pkg::*;

  localparam int UW = ROOT_W + 2;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  iter_mode_t       mode_r;
  logic [RAD_W-1:0] num_r;
  logic [UW-1:0]    rem_r;
  logic [NUM_W-1:0] res_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [UW-1:0] trial_a;
  logic [UW-1:0] trial_b;
  logic [UW-1:0] diff;
  logic          ge;

  always_comb begin
    if (mode_r == ITER_DIV) begin
      trial_a = {rem_r[UW-2:0], num_r[RAD_W-1]};
      trial_b = UW'(divisor);
    end else begin
      trial_a = {rem_r[UW-3:0], num_r[RAD_W-1 -: 2]};
      trial_b = {res_r[ROOT_W-1:0], 2'b01};
    end
    ge = (trial_a >= trial_b);
    diff = trial_a - trial_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        mode_r <= ctrl.mode;
        // left-align the dividend so both modes draw bits from the top
        if (ctrl.mode == ITER_DIV) begin
          num_r <= RAD_W'(operand) << (RAD_W - NUM_W);
          cnt_r <= CNT_W'(NUM_W);
        end else begin
          num_r <= RAD_W'(operand);
          cnt_r <= CNT_W'(ROOT_W);
        end
        rem_r  <= '0;
        res_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff : trial_a;
        res_r <= {res_r[NUM_W-2:0], ge};
        num_r <= (mode_r == ITER_DIV) ? (num_r << 1) : (num_r << 2);
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign result = res_r;
  assign done = done_r;

endmodule

@@ design/rmssd_stress_index.sv @@
// Top level of the RMSSD and stress index block: sequencer, ring control, config.
//
//  channel  | ports                              | direction | payload
//  ---------+------------------------------------+-----------+-------------------
//  input    | in_valid, in_stall, in_data        | in        | in_item_t
//  result   | out_valid, out_stall, out_data     | out       | out_item_t
//  config   | psel, penable, pwrite, paddr, ...  | in / out  | min_beats at 0x0
//
// A beat with enough history walks the stored intervals, then runs the
// bit-serial divider and square root in the shared compare-subtract unit.
// A beat with too few stored intervals goes straight to its result. One
// beat at a time: in_stall is high from acceptance until the result is
// loaded; a clear item leaves in_stall low and gives no result. A finished
// result waits in the output register while the next item is accepted.
// Reset is synchronous; it empties the history and sets min_beats to 6.
module rmssd_stress_index #(
  parameter int HISTORY_DEPTH = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rmssd_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rmssd_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmssd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rmssd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rmssd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready
);
  import rmssd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int CMP_W = (CW > MIN_BEATS_W) ? CW : MIN_BEATS_W;
  localparam int SQ_W = 2 * IBI_W;
  localparam int SUM_W = SQ_W + $clog2(HISTORY_DEPTH);
  localparam int NUM_W = SUM_W + 8;
  localparam int ROOT_W = (NUM_W + 1) / 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_SQRT,
    S_CALC,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [MIN_BEATS_W-1:0] min_beats_r, min_beats_nxt;
  logic [AW-1:0]          rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]          issue_left_r, issue_left_nxt;
  logic [CW-1:0]          pairs_r, pairs_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic                   sq_v_r, sq_v_nxt;
  logic [IBI_W-1:0]       prev_r, prev_nxt;
  logic [SQ_W-1:0]        prod_r, prod_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [BPM_W-1:0]       bpm_r, bpm_nxt;
  logic                   ok_r, ok_nxt;
  logic [RMSSD_W-1:0]     rq_r, rq_nxt;
  logic [13:0]            s80_r, s80_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   in_fire;
  logic                   cfg_write;
  logic [CW-1:0]          cnt_new;
  logic                   enough;
  logic [IBI_W-1:0]       rdata;
  logic [IBI_W:0]         diff;
  logic [IBI_W-1:0]       abs_d;
  logic [ROOT_W-1:0]      root;
  logic [RMSSD_W-1:0]     q;
  logic [13:0]            bonus_s80;
  logic [8:0]             s80_div16;
  logic [16:0]            stress_prod;
  iter_ctrl_t             iter_ctrl;
  logic [NUM_W-1:0]       iter_operand;
  logic [NUM_W-1:0]       iter_res;
  logic                   iter_done;

  assign in_stall = (state_r != S_IDLE);
  assign in_fire = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_IDX_MIN_BEATS) ? CFG_DATA_W'(min_beats_r) : '0;

  assign cnt_new = (count_r == CW'(HISTORY_DEPTH)) ? count_r : count_r + 1'b1;
  assign enough = (CMP_W'(cnt_new) >= CMP_W'(min_beats_r)) && (cnt_new >= CW'(2));

  rmssd_ring #(
    .DEPTH(HISTORY_DEPTH),
    .AW   (AW)
  ) u_ring (
    .clk  (clk),
    .we   (in_fire && (in_data.operation == OP_BEAT)),
    .waddr(wp_r),
    .wdata(in_data.interval_ms),
    .raddr(rd_addr_r),
    .rdata(rdata)
  );

  assign iter_operand = (state_r == S_WALK) ? {sum_r, 8'h00} : iter_res;

  rmssd_iter #(
    .NUM_W (NUM_W),
    .ROOT_W(ROOT_W),
    .DIV_W (CW)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (iter_ctrl),
    .operand(iter_operand),
    .divisor(pairs_r),
    .result (iter_res),
    .done   (iter_done)
  );

  always_comb begin
    diff = {1'b0, prev_r} - {1'b0, rdata};
    abs_d = diff[IBI_W] ? IBI_W'(-diff) : diff[IBI_W-1:0];
    root = iter_res[ROOT_W-1:0];

    if (rq_r < Q_LOW) begin
      q = Q_LOW;
    end else if (rq_r > Q_HIGH) begin
      q = Q_HIGH;
    end else begin
      q = rq_r;
    end

    if (bpm_r > BPM_HIGH) begin
      bonus_s80 = S80_BONUS_HIGH;
    end else if (bpm_r > BPM_MID) begin
      bonus_s80 = S80_BONUS_MID;
    end else if (bpm_r < BPM_LOW) begin
      bonus_s80 = S80_BONUS_LOW;
    end else begin
      bonus_s80 = '0;
    end

    // s80 stays within 1600..7840, so no clamp is needed; divide by 80 as /16 then /5
    s80_div16 = 9'((s80_r + S80_ROUND) >> 4);
    stress_prod = 17'(s80_div16) * 17'(DIV5_RECIP);
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wp_nxt = wp_r;
    min_beats_nxt = min_beats_r;
    rd_addr_nxt = rd_addr_r;
    issue_left_nxt = issue_left_r;
    pairs_nxt = pairs_r;
    rd_v_nxt = 1'b0;
    sq_v_nxt = 1'b0;
    prev_nxt = prev_r;
    prod_nxt = prod_r;
    sum_nxt = sum_r;
    bpm_nxt = bpm_r;
    ok_nxt = ok_r;
    rq_nxt = rq_r;
    s80_nxt = s80_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    iter_ctrl.start = 1'b0;
    iter_ctrl.mode = ITER_DIV;

    if (cfg_write && (paddr[2] == CFG_IDX_MIN_BEATS)) begin
      min_beats_nxt = pwdata[MIN_BEATS_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.operation == OP_CLEAR) begin
            count_nxt = '0;
            wp_nxt = '0;
          end else begin
            count_nxt = cnt_new;
            wp_nxt = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            // walk back from the interval just before this one
            rd_addr_nxt = (wp_r == '0) ? AW'(HISTORY_DEPTH - 1) : wp_r - 1'b1;
            issue_left_nxt = cnt_new - 1'b1;
            pairs_nxt = cnt_new - 1'b1;
            prev_nxt = in_data.interval_ms;
            sum_nxt = '0;
            bpm_nxt = in_data.heart_rate_bpm;
            ok_nxt = enough;
            state_nxt = enough ? S_WALK : S_FINISH;
          end
        end
      end
      S_WALK: begin
        if (issue_left_r != '0) begin
          issue_left_nxt = issue_left_r - 1'b1;
          rd_addr_nxt = (rd_addr_r == '0) ? AW'(HISTORY_DEPTH - 1) : rd_addr_r - 1'b1;
          rd_v_nxt = 1'b1;
        end
        if (rd_v_r) begin
          prod_nxt = SQ_W'(abs_d) * SQ_W'(abs_d);
          prev_nxt = rdata;
          sq_v_nxt = 1'b1;
        end
        if (sq_v_r) begin
          sum_nxt = sum_r + SUM_W'(prod_r);
        end
        if ((issue_left_r == '0) && !rd_v_r && !sq_v_r) begin
          iter_ctrl.start = 1'b1;
          iter_ctrl.mode = ITER_DIV;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (iter_done) begin
          iter_ctrl.start = 1'b1;
          iter_ctrl.mode = ITER_SQRT;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (iter_done) begin
          rq_nxt = (|root[ROOT_W-1:RMSSD_W]) ? '1 : root[RMSSD_W-1:0];
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        s80_nxt = S80_BASE + bonus_s80 - S80_SLOPE * 14'(q - Q_LOW);
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (ok_r) begin
            out_data_nxt.result_valid = 1'b1;
            out_data_nxt.rmssd_q4 = rq_r;
            out_data_nxt.stress_index = stress_prod[16:10];
          end else begin
            out_data_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      wp_r <= '0;
      min_beats_r <= MIN_BEATS_RESET;
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wp_r <= wp_nxt;
      min_beats_r <= min_beats_nxt;
      rd_v_r <= rd_v_nxt;
      sq_v_r <= sq_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_addr_r <= rd_addr_nxt;
    issue_left_r <= issue_left_nxt;
    pairs_r <= pairs_nxt;
    prev_r <= prev_nxt;
    prod_r <= prod_nxt;
    sum_r <= sum_nxt;
    bpm_r <= bpm_nxt;
    ok_r <= ok_nxt;
    rq_r <= rq_nxt;
    s80_r <= s80_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

@@ design/rmssd_chk.sv @@
// Port-level checker for the RMSSD stress index block, with its bind.
module rmssd_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rmssd_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rmssd_pkg::out_item_t out_data
);
  import rmssd_pkg::*;

  // with RMSSD clamped to 10..60 ms and a bonus of at most 8, stress lies in 20..98
  localparam logic [STRESS_W-1:0] STRESS_FLOOR = 7'd20;
  localparam logic [STRESS_W-1:0] STRESS_CEIL = 7'd98;

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.operation == OP_BEAT)) |=> in_stall)
    else $error("block took a second item right after a beat");

  a_stress_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.result_valid) |->
      (out_data.stress_index >= STRESS_FLOOR) && (out_data.stress_index <= STRESS_CEIL))
    else $error("stress index outside its reachable range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.result_valid) |->
      (out_data.rmssd_q4 == '0) && (out_data.stress_index == '0))
    else $error("invalid result carries nonzero values");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind rmssd_stress_index rmssd_chk u_rmssd_chk (.*);
